@@ hdl/i2ctrf_pkg.sv @@
`default_nettype none
package i2ctrf_pkg;

  localparam int unsigned MaxTargets = 8;
  localparam int unsigned TgtAddrW   = 7;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned DataW      = 8;
  localparam int unsigned PtrW       = 9;

  typedef logic [TgtAddrW-1:0] tgt_addr_t;
  typedef tgt_addr_t [MaxTargets-1:0] tgt_table_t;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoDevice = 2'd1,
    StOverflow = 2'd2,
    StAborted  = 2'd3
  } status_e;

endpackage
`default_nettype wire

@@ hdl/i2ctrf_match.sv @@
`default_nettype none
module i2ctrf_match import i2ctrf_pkg::*; #(
  parameter int unsigned TARGETS = 8,
  parameter int unsigned CW      = 3
) (
  input  tgt_table_t      table_i,
  input  tgt_addr_t       bus_addr_i,
  output logic            hit_o,
  output logic [CW-1:0]   idx_o
);

  always_comb begin
    logic stop;
    stop  = 1'b0;
    hit_o = 1'b0;
    idx_o = '0;
    for (int i = 0; i < TARGETS; i++) begin
      if (!stop) begin
        if (table_i[i] == '0) begin
          stop = 1'b1;
        end else if (table_i[i] == bus_addr_i) begin
          stop  = 1'b1;
          hit_o = 1'b1;
          idx_o = CW'(i);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/i2ctrf_store.sv @@
`default_nettype none
module i2ctrf_store import i2ctrf_pkg::*; #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o,
  output logic             busy_o
);

  logic [DataW-1:0] mem [DEPTH];
  logic [DataW-1:0] rdata_q;
  logic             clr_busy_q, clr_busy_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule
`default_nettype wire

@@ hdl/i2c_target_register_file_unit.sv @@
`default_nettype none
// Register file behind an I2C target port, emulating up to TARGETS chips of REGISTERS
// byte registers each. One data byte is taken per cycle unless the store is clearing or
// the output stalls; its result appears in the output register in the next cycle, from
// the store's single registered read port. After reset the store is cleared, one entry
// per cycle, all TARGETS*REGISTERS entries, with s_axis_tready held low; configuration
// writes are taken throughout. The user must write chip addresses via cfg (index 0..7)
// only while idle; the block does not enforce this. A zero address ends the list.
module i2c_target_register_file_unit import i2ctrf_pkg::*; #(
  parameter int unsigned TARGETS   = 8,
  parameter int unsigned REGISTERS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [TgtAddrW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,  // bus_address[6:0], write_byte[14:7], zero
  input  logic [2:0]          s_axis_tuser,  // func, message_start, transfer_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // read_byte
  output logic [1:0]          m_axis_tuser   // status
);

  localparam int unsigned Depth = TARGETS * REGISTERS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = (TARGETS > 1) ? $clog2(TARGETS) : 1;

  tgt_table_t         tgt_q;
  logic [PtrW-1:0]    ptr_q, ptr_d;
  logic               pw_q, pw_d;
  logic               ab_q, ab_d;
  logic               out_valid_q;
  status_e            status_q, status_d;
  logic               rd_sel_q, rd_sel_d;

  logic               accept;
  logic               busy;
  logic               hit;
  logic [CW-1:0]      chip_idx;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_addr;
  logic [DataW-1:0]   rdata;

  tgt_addr_t          in_addr;
  logic [DataW-1:0]   in_data;
  logic               in_func, in_msg, in_xfer;

  assign in_addr = s_axis_tdata[6:0];
  assign in_data = s_axis_tdata[14:7];
  assign in_func = s_axis_tuser[0];
  assign in_msg  = s_axis_tuser[1];
  assign in_xfer = s_axis_tuser[2];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
    end else if (cfg_valid_i) begin
      tgt_q[cfg_index_i] <= cfg_data_i;
    end
  end

  i2ctrf_match #(
    .TARGETS (TARGETS),
    .CW      (CW)
  ) u_match (
    .table_i    (tgt_q),
    .bus_addr_i (in_addr),
    .hit_o      (hit),
    .idx_o      (chip_idx)
  );

  always_comb begin
    logic [PtrW-1:0] ptr_eff;
    logic            pw_eff;
    logic            ab_eff;
    logic            ms;
    logic            load;
    ptr_eff  = in_xfer ? '0 : ptr_q;
    pw_eff   = in_xfer ? 1'b0 : pw_q;
    ab_eff   = in_xfer ? 1'b0 : ab_q;
    ms       = in_msg || in_xfer;
    load     = ms && in_func && !pw_eff;
    ptr_d    = ptr_eff;
    pw_d     = pw_eff;
    ab_d     = ab_eff;
    status_d = StOk;
    rd_sel_d = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = AW'(int'(chip_idx) * REGISTERS + int'(ptr_eff));
    if (ab_eff) begin
      status_d = StAborted;
    end else begin
      if (ms) begin
        pw_d = in_func;
      end
      if (!hit) begin
        status_d = StNoDevice;
      end else if (load) begin
        ptr_d = PtrW'(in_data);
      end else if (ptr_eff >= PtrW'(REGISTERS)) begin
        status_d = StOverflow;
        ab_d     = 1'b1;
      end else begin
        ptr_d = ptr_eff + PtrW'(1);
        if (in_func) begin
          mem_we = accept;
        end else begin
          mem_re   = accept;
          rd_sel_d = 1'b1;
        end
      end
    end
  end

  i2ctrf_store #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (in_data),
    .rdata_o (rdata),
    .busy_o  (busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      pw_q        <= 1'b0;
      ab_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        ptr_q       <= ptr_d;
        pw_q        <= pw_d;
        ab_q        <= ab_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rd_sel_q <= rd_sel_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = rd_sel_q ? rdata : '0;
  assign m_axis_tuser  = status_q;

endmodule
`default_nettype wire
